// ===== design/hard_edge_transition_select_assert.svh =====
// assertion macros for the transition select block
// no dependencies; included by the modules that check themselves
`ifndef HARD_EDGE_TRANSITION_SELECT_ASSERT_SVH
`define HARD_EDGE_TRANSITION_SELECT_ASSERT_SVH
`ifndef SYNTH
`define HETS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hets check failed");
`define HETS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hets check failed");
`else
`define HETS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HETS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/hets_pkg.sv =====
// shared constants, types and helpers of the transition select block
// no dependencies
`default_nettype none
package hets_pkg;
    localparam int MAX_SIDE    = 8192;
    localparam int XW          = 13;
    localparam int SIDE_W      = 14;
    localparam int PIX_W       = 32;
    localparam int PROG_W      = 16;
    localparam int CELL_W      = 13;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_STEPS   = 4;
    localparam int HASH_STAGES = 3;
    localparam int GEOM_STAGES = 4;
    localparam int CORE_LAT    = DIV_STAGES + HASH_STAGES;
    localparam int GEOM_PAD    = CORE_LAT - GEOM_STAGES;

    localparam logic [3:0] MODE_CUT      = 4'd0;
    localparam logic [3:0] MODE_WIPE_L   = 4'd1;
    localparam logic [3:0] MODE_WIPE_R   = 4'd2;
    localparam logic [3:0] MODE_WIPE_D   = 4'd3;
    localparam logic [3:0] MODE_WIPE_U   = 4'd4;
    localparam logic [3:0] MODE_OBL_R    = 4'd5;
    localparam logic [3:0] MODE_OBL_L    = 4'd6;
    localparam logic [3:0] MODE_CIRC_OUT = 4'd7;
    localparam logic [3:0] MODE_CIRC_IN  = 4'd8;
    localparam logic [3:0] MODE_DIAMOND  = 4'd9;
    localparam logic [3:0] MODE_OPEN     = 4'd10;
    localparam logic [3:0] MODE_CLOSE    = 4'd11;
    localparam logic [3:0] MODE_DISSOLVE = 4'd12;
    localparam logic [3:0] MODE_CHECKER  = 4'd13;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_PROGRESS = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_SEED     = 3'd4;
    localparam logic [2:0] REG_CELL     = 3'd5;

    localparam logic [31:0] HASH_MUL_A = 32'd374761393;
    localparam logic [31:0] HASH_MUL_B = 32'd668265263;
    localparam logic [31:0] HASH_MUL_C = 32'd1274126177;
    localparam logic [15:0] PROG_FULL  = 16'hFFFF;

    typedef struct packed {
        logic [3:0]        mode;
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic [PROG_W-1:0] p;
    } t_geom_cfg;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // floor(m / 65535) for m below 16384 * 65535; larger quotients wrap in the 14-bit result
    function automatic logic [SIDE_W-1:0] div_by_full(input logic [30:0] m);
        logic [14:0] qh;
        logic [16:0] t;
        logic [1:0]  adj;
        qh = m[30:16];
        t  = 17'(m[15:0]) + 17'(qh);
        if (t >= 17'd131070) begin
            adj = 2'd2;
        end else if (t >= 17'd65535) begin
            adj = 2'd1;
        end else begin
            adj = 2'd0;
        end
        return SIDE_W'(qh + 15'(adj));
    endfunction
endpackage
`default_nettype wire

// ===== design/hets_div.sv =====
// pipelined restoring divider for checker cell coordinates, two lanes
// depends on hets_pkg
`default_nettype none
module hets_div import hets_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [XW-1:0]     i_x,
    input  wire logic [XW-1:0]     i_y,
    input  wire logic [CELL_W-1:0] i_cs,
    input  wire logic              i_cell,
    output logic [XW-1:0]          o_a,
    output logic [XW-1:0]          o_b
);
    logic [XW-1:0] r_num [DIV_STAGES][2];
    logic [XW-1:0] r_rem [DIV_STAGES][2];
    logic [XW-1:0] r_quo [DIV_STAGES][2];
    logic [XW-1:0] r_raw [DIV_STAGES][2];
    logic [XW-1:0] w_in [2];

    assign w_in[0] = i_x;
    assign w_in[1] = i_y;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [XW-1:0] w_num_in, w_rem_in, w_quo_in, w_raw_in;
            logic [XW-1:0] n_num, n_rem, n_quo;
            if (s == 0) begin : g_first
                assign w_num_in = w_in[l];
                assign w_rem_in = '0;
                assign w_quo_in = '0;
                assign w_raw_in = w_in[l];
            end else begin : g_next
                assign w_num_in = r_num[s-1][l];
                assign w_rem_in = r_rem[s-1][l];
                assign w_quo_in = r_quo[s-1][l];
                assign w_raw_in = r_raw[s-1][l];
            end
            always_comb begin : p_step
                logic [XW:0] w_trial;
                n_num   = w_num_in;
                n_rem   = w_rem_in;
                n_quo   = w_quo_in;
                w_trial = '0;
                for (int k = 0; k < DIV_STEPS; k++) begin
                    if (s * DIV_STEPS + k < XW) begin
                        w_trial = {n_rem, n_num[XW-1]};
                        n_num   = {n_num[XW-2:0], 1'b0};
                        if (w_trial >= {1'b0, i_cs}) begin
                            n_rem = XW'(w_trial - {1'b0, i_cs});
                            n_quo = {n_quo[XW-2:0], 1'b1};
                        end else begin
                            n_rem = w_trial[XW-1:0];
                            n_quo = {n_quo[XW-2:0], 1'b0};
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[s][l] <= n_num;
                    r_rem[s][l] <= n_rem;
                    r_quo[s][l] <= n_quo;
                    r_raw[s][l] <= w_raw_in;
                end
            end
        end
    end

    assign o_a = i_cell ? r_quo[DIV_STAGES-1][0] : r_raw[DIV_STAGES-1][0];
    assign o_b = i_cell ? r_quo[DIV_STAGES-1][1] : r_raw[DIV_STAGES-1][1];
endmodule
`default_nettype wire

// ===== design/hets_hash.sv =====
// three stage pixel hash and reveal compare for dissolve and checker
// depends on hets_pkg
`default_nettype none
module hets_hash import hets_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [XW-1:0]     i_a,
    input  wire logic [XW-1:0]     i_b,
    input  wire logic [31:0]       i_seed,
    input  wire logic [PROG_W-1:0] i_p,
    output logic                   o_take
);
    logic [31:0] r_g0, r_g2;
    logic        r_take;
    logic [31:0] n_g0, w_g1, n_g2, w_g3;
    logic [23:0] w_v;
    logic [39:0] w_lhs, w_rhs;

    assign n_g0  = 32'(32'(i_a) * HASH_MUL_A) + 32'(32'(i_b) * HASH_MUL_B);
    assign w_g1  = r_g0 ^ i_seed;
    assign n_g2  = 32'((w_g1 ^ (w_g1 >> 13)) * HASH_MUL_C);
    assign w_g3  = r_g2 ^ (r_g2 >> 16);
    assign w_v   = w_g3[23:0];
    assign w_lhs = {w_v, 16'h0} - 40'(w_v);
    assign w_rhs = {i_p, 24'h0} - 40'(i_p);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g0   <= n_g0;
            r_g2   <= n_g2;
            r_take <= (w_lhs < w_rhs);
        end
    end

    assign o_take = r_take;
endmodule
`default_nettype wire

// ===== design/hets_geom.sv =====
// geometric masks: wipes, obliques, circles, diamond and curtains
// depends on hets_pkg
`default_nettype none
module hets_geom import hets_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [XW-1:0] i_x,
    input  wire logic [XW-1:0] i_y,
    input  wire t_geom_cfg     i_cfg,
    output logic               o_take
);
    // stage 1
    logic [XW-1:0]        r1_x;
    logic signed [15:0]   r1_dx, r1_dy, r1_s;
    logic [29:0]          r1_lx, r1_ly, r1_wp, r1_wq, r1_hp, r1_hq;
    logic [30:0]          r1_pwh;
    logic [27:0]          r1_w2, r1_h2;
    logic [31:0]          r1_p2, r1_q2;
    logic [29:0]          r1_xy;
    // stage 2
    logic [XW-1:0]        r2_x;
    logic [29:0]          r2_dx2, r2_dy2;
    logic [27:0]          r2_rad2;
    logic [31:0]          r2_p2, r2_q2;
    logic [SIDE_W-1:0]    r2_gap, r2_c;
    logic                 r2_take;
    // stage 3
    logic [30:0]          r3_dist2;
    logic [59:0]          r3_prad, r3_qrad;
    logic                 r3_take;
    // stage 4 and alignment
    logic                 r4_take;
    logic                 r_pad [GEOM_PAD];

    logic [PROG_W-1:0]    w_q;
    logic [SIDE_W-1:0]    w_x1, w_y1, w_xs;
    logic [14:0]          w_wh;
    always_comb begin
        w_q  = PROG_FULL - i_cfg.p;
        w_x1 = SIDE_W'(i_x) + SIDE_W'(1);
        w_y1 = SIDE_W'(i_y) + SIDE_W'(1);
        w_xs = SIDE_W'(i_x) + SIDE_W'(i_y);
        w_wh = 15'(i_cfg.w) + 15'(i_cfg.h);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x   <= i_x;
            r1_dx  <= $signed({2'b0, i_x, 1'b0}) - $signed({2'b0, i_cfg.w});
            r1_dy  <= $signed({2'b0, i_y, 1'b0}) - $signed({2'b0, i_cfg.h});
            r1_s   <= $signed({2'b0, i_cfg.w}) - $signed({3'b0, i_x}) + $signed({3'b0, i_y});
            r1_lx  <= {w_x1, 16'h0} - 30'(w_x1);
            r1_ly  <= {w_y1, 16'h0} - 30'(w_y1);
            r1_xy  <= {w_xs, 16'h0} - 30'(w_xs);
            r1_wp  <= 30'(i_cfg.w) * 30'(i_cfg.p);
            r1_wq  <= 30'(i_cfg.w) * 30'(w_q);
            r1_hp  <= 30'(i_cfg.h) * 30'(i_cfg.p);
            r1_hq  <= 30'(i_cfg.h) * 30'(w_q);
            r1_pwh <= 31'(i_cfg.p) * 31'(w_wh);
            r1_w2  <= 28'(i_cfg.w) * 28'(i_cfg.w);
            r1_h2  <= 28'(i_cfg.h) * 28'(i_cfg.h);
            r1_p2  <= 32'(i_cfg.p) * 32'(i_cfg.p);
            r1_q2  <= 32'(w_q) * 32'(w_q);
        end
    end

    logic signed [31:0] w_sqx, w_sqy;
    logic [13:0]        w_adx, w_ady;
    logic [14:0]        w_ads;
    logic [30:0]        w_dl;
    logic signed [32:0] w_sl;
    logic [31:0]        w_m2;
    logic               n2_take;
    always_comb begin
        w_sqx = r1_dx * r1_dx;
        w_sqy = r1_dy * r1_dy;
        w_adx = r1_dx[15] ? 14'(-r1_dx) : 14'(r1_dx);
        w_ady = r1_dy[15] ? 14'(-r1_dy) : 14'(r1_dy);
        w_ads = 15'(w_adx) + 15'(w_ady);
        w_dl  = {w_ads, 16'h0} - 31'(w_ads);
        w_sl  = {r1_s[15], r1_s, 16'h0} - 33'(r1_s);
        w_m2  = 32'(r1_wp) + 32'd65535;
        case (i_cfg.mode)
            MODE_WIPE_L:  n2_take = (r1_lx <= r1_wp);
            MODE_WIPE_R:  n2_take = (r1_lx > r1_wq);
            MODE_WIPE_D:  n2_take = (r1_ly <= r1_hp);
            MODE_WIPE_U:  n2_take = (r1_ly > r1_hq);
            MODE_OBL_R:   n2_take = (31'(r1_xy) < r1_pwh);
            MODE_OBL_L:   n2_take = (w_sl < $signed({2'b0, r1_pwh}));
            MODE_DIAMOND: n2_take = (w_dl <= r1_pwh);
            default:      n2_take = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x    <= r1_x;
            r2_dx2  <= w_sqx[29:0];
            r2_dy2  <= w_sqy[29:0];
            r2_rad2 <= r1_w2 + r1_h2;
            r2_p2   <= r1_p2;
            r2_q2   <= r1_q2;
            r2_gap  <= div_by_full(31'(r1_wp) + 31'd32767);
            r2_c    <= div_by_full(w_m2[31:1]);
            r2_take <= n2_take;
        end
    end

    logic [SIDE_W-1:0] w_lo, w_wc;
    logic [14:0]       w_hi;
    logic              w_open, w_close, n3_take;
    always_comb begin
        w_lo    = (i_cfg.w - r2_gap) >> 1;
        w_hi    = 15'(w_lo) + 15'(r2_gap);
        w_wc    = i_cfg.w - r2_c;
        w_open  = (SIDE_W'(r2_x) >= w_lo) && (15'(r2_x) < w_hi);
        w_close = (SIDE_W'(r2_x) < r2_c) || (SIDE_W'(r2_x) >= w_wc);
        case (i_cfg.mode)
            MODE_OPEN:  n3_take = w_open;
            MODE_CLOSE: n3_take = w_close;
            default:    n3_take = r2_take;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_dist2 <= 31'(r2_dx2) + 31'(r2_dy2);
            r3_prad  <= 60'(r2_p2) * 60'(r2_rad2);
            r3_qrad  <= 60'(r2_q2) * 60'(r2_rad2);
            r3_take  <= n3_take;
        end
    end

    logic [46:0] w_t1;
    logic [62:0] w_lhs;
    logic        n4_take;
    always_comb begin
        w_t1  = {r3_dist2, 16'h0} - 47'(r3_dist2);
        w_lhs = {w_t1, 16'h0} - 63'(w_t1);
        case (i_cfg.mode)
            MODE_CIRC_OUT: n4_take = (w_lhs <= 63'(r3_prad));
            MODE_CIRC_IN:  n4_take = !(w_lhs <= 63'(r3_qrad));
            default:       n4_take = r3_take;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_take <= n4_take;
            r_pad[0] <= r4_take;
            for (int i = 1; i < GEOM_PAD; i++) begin
                r_pad[i] <= r_pad[i-1];
            end
        end
    end

    assign o_take = r_pad[GEOM_PAD-1];
endmodule
`default_nettype wire

// ===== design/hard_edge_transition_select.sv =====
// Hard-edged transition select, top level.
// Depends on hets_pkg, hets_div, hets_hash, hets_geom and the assert header.
//
// Input channel: i_valid / o_stall with i_x_pos, i_y_pos, i_old_pixel,
// i_new_pixel. Output channel: o_valid / i_stall with o_pixel_out and
// o_took_new. A word moves at a clock edge with valid high and stall low.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 mode,
// 1 progress, 2 width, 3 height, 4 hash seed, 5 cell size); other indexes
// are ignored. Write only while no pixel is in flight.
// Throughput: one pixel per clock while the output is not stalled. A word
// accepted at an edge passes the four stage cell divider and the three
// stage hash, with the geometric masks running alongside, and is then
// loaded into the output register.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults. When the receiver stalls a valid output word, the
// whole pipeline holds and o_stall rises; nothing is lost or repeated.
`default_nettype none
`include "hard_edge_transition_select_assert.svh"
module hard_edge_transition_select import hets_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [XW-1:0]    i_x_pos,
    input  wire logic [XW-1:0]    i_y_pos,
    input  wire logic [PIX_W-1:0] i_old_pixel,
    input  wire logic [PIX_W-1:0] i_new_pixel,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_took_new,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [31:0]      i_cfg_data
);
    logic [3:0]        r_mode;
    logic [PROG_W-1:0] r_prog;
    logic [SIDE_W-1:0] r_fw, r_fh;
    logic [31:0]       r_seed;
    logic [CELL_W-1:0] r_cell;

    logic [CORE_LAT-1:0] r_vld;
    logic                r_out_vld;
    logic [PIX_W-1:0]    r_old [CORE_LAT];
    logic [PIX_W-1:0]    r_new [CORE_LAT];
    logic [PIX_W-1:0]    r_out_pix;
    logic                r_out_took;

    logic              w_adv;
    logic [CELL_W-1:0] w_cs;
    logic              w_cell, w_hashed;
    logic [XW-1:0]     w_a, w_b;
    logic              w_hash_take, w_geom_take, w_take;
    t_geom_cfg         w_gcfg;

    assign w_adv    = !(r_out_vld && i_stall);
    assign o_stall  = !w_adv;
    assign w_cs     = (r_cell == '0) ? CELL_W'(1) : r_cell;
    assign w_cell   = (r_mode == MODE_CHECKER);
    assign w_hashed = (r_mode == MODE_DISSOLVE) || (r_mode == MODE_CHECKER);
    assign w_gcfg   = '{mode: r_mode, w: clamp_side(r_fw), h: clamp_side(r_fh), p: r_prog};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CUT;
            r_prog <= '0;
            r_fw   <= SIDE_W'(1920);
            r_fh   <= SIDE_W'(1080);
            r_seed <= 32'd1811187708;
            r_cell <= CELL_W'(48);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:     r_mode <= i_cfg_data[3:0];
                REG_PROGRESS: r_prog <= i_cfg_data[PROG_W-1:0];
                REG_WIDTH:    r_fw   <= i_cfg_data[SIDE_W-1:0];
                REG_HEIGHT:   r_fh   <= i_cfg_data[SIDE_W-1:0];
                REG_SEED:     r_seed <= i_cfg_data;
                REG_CELL:     r_cell <= i_cfg_data[CELL_W-1:0];
                default:      ;
            endcase
        end
    end

    hets_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (i_x_pos),
        .i_y    (i_y_pos),
        .i_cs   (w_cs),
        .i_cell (w_cell),
        .o_a    (w_a),
        .o_b    (w_b)
    );

    hets_hash u_hash (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_seed (r_seed),
        .i_p    (r_prog),
        .o_take (w_hash_take)
    );

    hets_geom u_geom (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (i_x_pos),
        .i_y    (i_y_pos),
        .i_cfg  (w_gcfg),
        .o_take (w_geom_take)
    );

    assign w_take = w_hashed ? w_hash_take : w_geom_take;

    // valid bits travel with the pixel words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[CORE_LAT-2:0], i_valid};
            r_out_vld <= r_vld[CORE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_old[0] <= i_old_pixel;
            r_new[0] <= i_new_pixel;
            for (int i = 1; i < CORE_LAT; i++) begin
                r_old[i] <= r_old[i-1];
                r_new[i] <= r_new[i-1];
            end
            r_out_pix  <= w_take ? r_new[CORE_LAT-1] : r_old[CORE_LAT-1];
            r_out_took <= w_take;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_pixel_out = r_out_pix;
    assign o_took_new  = r_out_took;

    `HETS_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_stall, r_out_vld)
    `HETS_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])
    `HETS_ASSERT_NXT(a_drain_to_out, i_clk, i_rst_n, r_vld[CORE_LAT-1] && !o_stall, r_out_vld)
endmodule
`default_nettype wire

// ===== test/hard_edge_transition_select_test.sv =====
// self-checking testbench for the hard-edged transition select block
// depends on hets_pkg and hard_edge_transition_select; predicts each pixel word
`default_nettype none
module hard_edge_transition_select_test;
    import hets_pkg::*;

    typedef struct {
        logic [XW-1:0]    x;
        logic [XW-1:0]    y;
        logic [PIX_W-1:0] oldp;
        logic [PIX_W-1:0] newp;
    } t_pixel_in;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             took;
    } t_pixel_out;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [XW-1:0]    i_x_pos = '0;
    logic [XW-1:0]    i_y_pos = '0;
    logic [PIX_W-1:0] i_old_pixel = '0;
    logic [PIX_W-1:0] i_new_pixel = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [PIX_W-1:0] o_pixel_out;
    logic             o_took_new;
    logic             i_cfg_we = 1'b0;
    logic [2:0]       i_cfg_idx = '0;
    logic [31:0]      i_cfg_data = '0;

    hard_edge_transition_select DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [3:0]  cur_mode;
    logic [15:0] cur_prog;
    logic [13:0] cur_w, cur_h;
    logic [31:0] cur_seed;
    logic [12:0] cur_cell;

    t_pixel_in  pending_pixels[$];
    t_pixel_out expected_pixels[$];
    int errors = 0;
    int words_checked = 0;
    int modes_seen = 0;
    bit hold_off = 1'b0;
    bit long_stall = 1'b0;
    bit in_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    function automatic logic [23:0] pixel_hash(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] g;
        g = a * 32'd374761393 + b * 32'd668265263;
        g ^= cur_seed;
        g = (g ^ (g >> 13)) * 32'd1274126177;
        g ^= g >> 16;
        return g[23:0];
    endfunction

    function automatic t_pixel_out predict_pixel(input t_pixel_in it);
        longint x, y, w, h, p, q, dx, dy, d2, r2, cs, gap, lo, c, ax, ay;
        bit take;
        t_pixel_out r;
        x = it.x; y = it.y;
        w = (cur_w == 0) ? 1 : (cur_w > MAX_SIDE ? MAX_SIDE : cur_w);
        h = (cur_h == 0) ? 1 : (cur_h > MAX_SIDE ? MAX_SIDE : cur_h);
        p = cur_prog; q = 65535 - p;
        dx = 2 * x - w; dy = 2 * y - h;
        d2 = dx * dx + dy * dy; r2 = w * w + h * h;
        cs = (cur_cell == 0) ? 1 : cur_cell;
        ax = dx < 0 ? -dx : dx; ay = dy < 0 ? -dy : dy;
        case (cur_mode)
            MODE_WIPE_L: take = (x + 1) * 65535 <= w * p;
            MODE_WIPE_R: take = (x + 1) * 65535 > w * q;
            MODE_WIPE_D: take = (y + 1) * 65535 <= h * p;
            MODE_WIPE_U: take = (y + 1) * 65535 > h * q;
            MODE_OBL_R: take = (x + y) * 65535 < p * (w + h);
            MODE_OBL_L: take = ((w - x) + y) * 65535 < p * (w + h);
            MODE_CIRC_OUT: take = d2 * 65535 * 65535 <= p * p * r2;
            MODE_CIRC_IN: take = !(d2 * 65535 * 65535 <= q * q * r2);
            MODE_DIAMOND: take = (ax + ay) * 65535 <= p * (w + h);
            MODE_OPEN: begin
                gap = (2 * p * w + 65535) / 131070;
                lo = (w - gap) / 2;
                take = x >= lo && x < lo + gap;
            end
            MODE_CLOSE: begin
                c = (2 * p * w + 131070) / 262140;
                take = x < c || x >= w - c;
            end
            MODE_DISSOLVE: take = longint'(pixel_hash(32'(x), 32'(y))) * 65535 < p * 16777215;
            MODE_CHECKER:
                take = longint'(pixel_hash(32'(x / cs), 32'(y / cs))) * 65535 < p * 16777215;
            default: take = 1'b1;
        endcase
        r.pix = take ? it.newp : it.oldp;
        r.took = take;
        return r;
    endfunction

    // input sampler: predict each word at the edge that takes it
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            expected_pixels.push_back(predict_pixel('{i_x_pos, i_y_pos, i_old_pixel,
                                                      i_new_pixel}));
        end
    end

    // driver: bursts and gaps, fed from the pending queue
    always @(negedge i_clk) begin
        t_pixel_in it;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_pixels.size() > 0 && !hold_off) begin
                it = pending_pixels.pop_front();
                i_valid <= 1'b1;
                i_x_pos <= it.x;
                i_y_pos <= it.y;
                i_old_pixel <= it.oldp;
                i_new_pixel <= it.newp;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    int long_count = 0;
    always @(negedge i_clk) begin
        stall_phase++;
        if (long_stall && long_count < 60) begin
            long_count++;
            i_stall <= 1'b1;
        end else if (stall_phase % 400 < 150) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pixel_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                report("unexpected word", o_pixel_out, '0);
            end else begin
                e = expected_pixels.pop_front();
                words_checked++;
                if (o_pixel_out !== e.pix) report("pixel_out", o_pixel_out, e.pix);
                if (o_took_new !== e.took) report("took_new", 32'(o_took_new), 32'(e.took));
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE: cur_mode = val[3:0];
            REG_PROGRESS: cur_prog = val[15:0];
            REG_WIDTH: cur_w = val[13:0];
            REG_HEIGHT: cur_h = val[13:0];
            REG_SEED: cur_seed = val;
            REG_CELL: cur_cell = val[12:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_pixels.size() == 0);
        repeat (2) @(negedge i_clk);
        while (i_valid || expected_pixels.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic queue_pixel(input int x, input int y);
        pending_pixels.push_back('{13'(x), 13'(y), $urandom, $urandom});
    endtask

    function automatic int pick_coord(input int side);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 8191;
            2: return side > 0 ? (side - 1) % 8192 : 0;
            default: return $urandom_range(0, side > 8191 ? 8191 : (side < 1 ? 0 : side));
        endcase
    endfunction

    function automatic logic [31:0] pick_side();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 8192;
            3: return 16383;
            4: return $urandom_range(1, 8192);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    initial begin
        int side;
        cur_mode = MODE_CUT; cur_prog = 0; cur_w = 1920; cur_h = 1080;
        cur_seed = 32'd1811187708; cur_cell = 48;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default registers, cut mode, field extremes, ignored indexes, an undefined mode, each mode
        queue_pixel(0, 0);
        queue_pixel(8191, 8191);
        pending_pixels.push_back('{13'h1555, 13'h0AAA, 32'hFFFFFFFF, 32'h0});
        pending_pixels.push_back('{13'h0AAA, 13'h1555, 32'h0, 32'hFFFFFFFF});
        drain();
        write_reg(3'd6, 32'hFFFFFFFF);
        write_reg(3'd7, 32'h0);
        write_reg(REG_MODE, 15);
        queue_pixel(5, 5);
        drain();
        for (int m = 1; m <= 13; m++) begin
            write_reg(REG_MODE, m);
            write_reg(REG_PROGRESS, 32'h8000 + m);
            write_reg(REG_WIDTH, 16);
            write_reg(REG_HEIGHT, 12);
            queue_pixel(7, 5);
            queue_pixel(20, 0);
            drain();
        end

        // random phases across settings and extremes
        for (int ph = 0; ph < 48; ph++) begin
            write_reg(REG_MODE, (ph % 8 == 7) ? $urandom_range(14, 15) : ph % 14);
            case (ph % 5)
                0: write_reg(REG_PROGRESS, 0);
                1: write_reg(REG_PROGRESS, 65535);
                default: write_reg(REG_PROGRESS, $urandom_range(0, 65535));
            endcase
            write_reg(REG_WIDTH, pick_side());
            write_reg(REG_HEIGHT, pick_side());
            write_reg(REG_SEED, $urandom);
            case (ph % 4)
                0: write_reg(REG_CELL, 0);
                1: write_reg(REG_CELL, 8191);
                default: write_reg(REG_CELL, $urandom_range(1, 40));
            endcase
            modes_seen++;
            side = cur_w > cur_h ? cur_w : cur_h;
            for (int k = 0; k < 30; k++) queue_pixel(pick_coord(side), pick_coord(side));
            if (ph == 10) begin
                long_stall = 1'b1;
            end
            if (ph == 20) begin
                hold_off = 1'b1;
                while (expected_pixels.size() != 0 || i_valid) @(negedge i_clk);
                hold_off = 1'b0;
            end
            drain();
        end
    end

    initial begin
        wait (modes_seen == 48);
        wait (pending_pixels.size() == 0 && expected_pixels.size() == 0 && !i_valid);
        repeat (30) @(posedge i_clk);
        $display("covered all modes over 48 register settings, %0d words checked",
                 words_checked);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/hets_pkg.sv
design/hets_div.sv
design/hets_hash.sv
design/hets_geom.sv
design/hard_edge_transition_select.sv
test/hard_edge_transition_select_test.sv
